// ----- hw/rtl/periodic_task_tick_scheduler_core_assert.svh -----
// Assertion macros for the periodic task tick scheduler core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PTTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptts assertion failed");
// next-cycle implication
`define PTTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptts assertion failed");
`else
`define PTTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define PTTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/ptts_pkg.sv -----
// Shared types and constants for the periodic task tick scheduler.
// No dependencies.
`default_nettype none
package ptts_pkg;

   localparam int TASK_SLOTS  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int NREP_W      = $clog2(MAX_RESULTS + 1);
   localparam int ID_W        = 8;
   localparam int TIME_W      = 16;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_CREATE = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_RESUME = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ID_W-1:0]   task_id;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] start_delay;
      logic              has_action;
   } req_type;

   typedef struct packed {
      logic            fired;
      logic [ID_W-1:0] fired_id;
      logic            last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start_tick;
      logic apply_cmd;
      logic scan_step;
      logic push_final;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic step_ok;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ptts_ctrl.sv -----
// Controller FSM: idle / slot scan / final result.
// Depends on ptts_pkg.
`default_nettype none
module ptts_ctrl
   import ptts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire cmd_type       req_cmd,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       ctrl_cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_TICK) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.step_ok && status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      ctrl_cmd  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready            = 1'b1;
            ctrl_cmd.start_tick  = req_valid && (req_cmd == CMD_TICK);
            ctrl_cmd.apply_cmd   = req_valid && (req_cmd != CMD_TICK);
         end
         ST_SCAN: begin
            ctrl_cmd.scan_step   = status.step_ok;
         end
         ST_FINISH: begin
            ctrl_cmd.push_final  = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ptts_dp.sv -----
// Datapath: slot tables, scan pointer, pending firing and result register.
// Depends on ptts_pkg.
`default_nettype none
module ptts_dp
   import ptts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_data,
   input  wire ctrl_cmd_type ctrl_cmd,
   output dp_status_type     status,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data
);

   logic [TIME_W-1:0] period_ff    [TASK_SLOTS];
   logic [TIME_W-1:0] countdown_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] present_ff, present_in;
   logic [TASK_SLOTS-1:0] suspended_ff, suspended_in;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [NREP_W-1:0] nrep_ff, nrep_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0] pend_id_ff, pend_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              id_ok;
   logic [SLOT_W-1:0] wr_slot;
   logic              slot_active, slot_fire, slot_report;
   logic [TIME_W-1:0] cd_cur, cd_next_in;
   logic              out_free;

   assign id_ok   = req_data.task_id < ID_W'(TASK_SLOTS);
   assign wr_slot = req_data.task_id[SLOT_W-1:0];

   assign cd_cur      = countdown_ff[idx_ff];
   assign slot_active = present_ff[idx_ff] && !suspended_ff[idx_ff];
   assign slot_fire   = slot_active && (cd_cur == '0);
   assign slot_report = slot_fire && (nrep_ff < NREP_W'(MAX_RESULTS));
   assign cd_next_in  = slot_fire ? (period_ff[idx_ff] - TIME_W'(1))
                                  : (cd_cur - TIME_W'(1));

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.out_free  = out_free;
      status.scan_last = (idx_ff == SLOT_W'(TASK_SLOTS - 1));
      // a second reported firing pushes the held one out
      status.step_ok   = !(slot_report && pend_valid_ff) || out_free;
   end

   // flag and control next state
   always_comb begin
      present_in    = present_ff;
      suspended_in  = suspended_ff;
      idx_in        = idx_ff;
      nrep_in       = nrep_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (ctrl_cmd.start_tick || ctrl_cmd.apply_cmd) begin
         idx_in        = '0;
         nrep_in       = '0;
         pend_valid_in = 1'b0;
      end

      if (ctrl_cmd.apply_cmd && id_ok) begin
         case (req_data.cmd)
            CMD_CREATE: present_in[wr_slot]   = req_data.has_action;
            CMD_STOP:   suspended_in[wr_slot] = 1'b1;
            CMD_RESUME: suspended_in[wr_slot] = 1'b0;
            default:    present_in            = present_ff;
         endcase
      end

      if (ctrl_cmd.scan_step) begin
         idx_in = idx_ff + SLOT_W'(1);
         if (slot_report) begin
            if (pend_valid_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.fired    = 1'b1;
               rsp_data_in.fired_id = ID_W'(pend_id_ff);
               rsp_data_in.last     = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_id_in    = idx_ff;
            nrep_in       = nrep_ff + NREP_W'(1);
         end
      end

      if (ctrl_cmd.push_final) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.fired    = pend_valid_ff;
         rsp_data_in.fired_id = pend_valid_ff ? ID_W'(pend_id_ff) : '0;
         rsp_data_in.last     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         suspended_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         nrep_ff       <= '0;
      end else begin
         present_ff    <= present_in;
         suspended_ff  <= suspended_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         nrep_ff       <= nrep_in;
      end
   end

   // payload: tables are only read once create has set present
   always_ff @(posedge clock) begin
      pend_id_ff  <= pend_id_in;
      rsp_data_ff <= rsp_data_in;
      if (ctrl_cmd.apply_cmd && id_ok && (req_data.cmd == CMD_CREATE)) begin
         period_ff[wr_slot]    <= req_data.period;
         countdown_ff[wr_slot] <= req_data.start_delay;
      end else if (ctrl_cmd.scan_step && slot_active) begin
         countdown_ff[idx_ff]  <= cd_next_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/periodic_task_tick_scheduler_core.sv -----
// Top level of the periodic task tick scheduler: controller plus datapath.
// Depends on ptts_pkg, ptts_ctrl, ptts_dp and the assertion macro header.
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-----------------------------
//  request | req_valid req_ready req_data   | in        | cmd task_id period delay act
//  result  | rsp_valid rsp_ready rsp_data   | out       | fired fired_id last
//
// Tick: one slot per cycle through the countdown/period tables unless rsp_ready stalls
//   the scan; accept, a scan of all TASK_SLOTS slots, then the closing beat.
// Create / stop / resume: applied at accept; the result beat follows from ST_FINISH.
// A firing is held until the next one is reported, so the final beat can carry last.
// rsp_ready low stalls the scan only when a held firing must leave.
// Synchronous reset clears flags and control; tables need no clearing pass.
`default_nettype none
`include "periodic_task_tick_scheduler_core_assert.svh"
module periodic_task_tick_scheduler_core
   import ptts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type status;

   ptts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .status    (status),
      .ctrl_cmd  (ctrl_cmd)
   );

   ptts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl_cmd  (ctrl_cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one item at a time: busy right after an accept
   `PTTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // a non-fired beat is always the only, final one
   `PTTS_ASSERT_IMPLY(a_nofire_last, clock, reset, rsp_valid && !rsp_data.fired, rsp_data.last)
   `PTTS_ASSERT_IMPLY(a_nofire_id, clock, reset, rsp_valid && !rsp_data.fired, rsp_data.fired_id == '0)
   // final push is never issued while the result register is blocked
   `PTTS_ASSERT_IMPLY(a_push_free, clock, reset, ctrl_cmd.push_final, !rsp_valid || rsp_ready)
   // closing the scan always leads to the final beat
   `PTTS_ASSERT_NEXT(a_scan_end, clock, reset, ctrl_cmd.scan_step && status.scan_last, !req_ready)

endmodule
`default_nettype wire
